// File: design/tcp_pkg.sv
// ----------------------------------------------------------------------------
// tcp_pkg: shared types and constants of the 8-bit timer/counter
// Payload structs, configuration codes and the compare output action.
// ----------------------------------------------------------------------------
package tcp_pkg;

    localparam int COUNTER_WIDTH = 8;
    localparam int PRESCALE_WIDTH = 10;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH = 8;

    typedef enum logic [1:0] {
        WM_NORMAL = 2'd0,
        WM_CTC    = 2'd1,
        WM_FAST   = 2'd2,
        WM_PHASE  = 2'd3
    } tcp_wave_t;

    typedef enum logic [1:0] {
        COM_OFF    = 2'd0,
        COM_TOGGLE = 2'd1,
        COM_CLEAR  = 2'd2,
        COM_SET    = 2'd3
    } tcp_com_t;

    localparam logic [2:0] CS_STOP    = 3'd0;
    localparam logic [2:0] CS_DIV1    = 3'd1;
    localparam logic [2:0] CS_DIV8    = 3'd2;
    localparam logic [2:0] CS_DIV64   = 3'd3;
    localparam logic [2:0] CS_DIV256  = 3'd4;
    localparam logic [2:0] CS_DIV1024 = 3'd5;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_WAVE_MODE    = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_COM_MODE     = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CLOCK_SELECT = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_COMPARE      = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_OVF_IRQ_EN   = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CMP_IRQ_EN   = 3'd5;

    typedef struct packed {
        tcp_wave_t  wave_mode;
        tcp_com_t   compare_output_mode;
        logic [2:0] clock_select;
        logic [7:0] compare_value;
        logic       overflow_irq_enable;
        logic       compare_irq_enable;
    } tcp_cfg_t;

    typedef struct packed {
        logic       load_counter;
        logic [7:0] load_value;
        logic       clear_overflow_flag;
        logic       clear_compare_flag;
        logic       force_compare;
    } tcp_in_t;

    typedef struct packed {
        logic [7:0] count_value;
        logic       wave_out;
        logic       overflow_flag;
        logic       compare_flag;
        logic       overflow_irq;
        logic       compare_irq;
    } tcp_out_t;

    function automatic logic tcp_action(input logic pin, input tcp_com_t act);
        logic res;
        res = pin;
        case (act)
            COM_TOGGLE: res = ~pin;
            COM_CLEAR:  res = 1'b0;
            COM_SET:    res = 1'b1;
            default:    res = pin;
        endcase
        return res;
    endfunction

endpackage

// File: design/tcp_cfg_regs.sv
// ----------------------------------------------------------------------------
// tcp_cfg_regs: configuration register file
// Decodes register writes by index; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module tcp_cfg_regs
    import tcp_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    output tcp_cfg_t                   cfg
);

    tcp_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_WAVE_MODE:    cfg_reg.wave_mode <= tcp_wave_t'(cfg_data[1:0]);
                REG_COM_MODE:     cfg_reg.compare_output_mode <= tcp_com_t'(cfg_data[1:0]);
                REG_CLOCK_SELECT: cfg_reg.clock_select <= cfg_data[2:0];
                REG_COMPARE:      cfg_reg.compare_value <= cfg_data[7:0];
                REG_OVF_IRQ_EN:   cfg_reg.overflow_irq_enable <= cfg_data[0];
                REG_CMP_IRQ_EN:   cfg_reg.compare_irq_enable <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: design/tcp_core.sv
// ----------------------------------------------------------------------------
// tcp_core: timer state and next-state logic
// Prescaler, counter, direction, pin level and flags; advances one system
// clock per step and presents the values after that clock.
// ----------------------------------------------------------------------------
module tcp_core
    import tcp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  tcp_cfg_t cfg,
    input  logic     step,
    input  tcp_in_t  item,
    output tcp_out_t result
);

    localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = '1;
    localparam logic [COUNTER_WIDTH-1:0] CNT_ONE = COUNTER_WIDTH'(1);

    logic [PRESCALE_WIDTH-1:0] prescale_reg, prescale_next;
    logic [COUNTER_WIDTH-1:0]  counter_reg, counter_next;
    logic                      down_reg, down_next;
    logic                      pin_reg, pin_next;
    logic                      ovf_reg, ovf_next;
    logic                      cmp_reg, cmp_next;

    logic tick;
    logic match;
    logic at_max;
    logic pwm_on;
    logic inv;
    logic up;

    always_comb begin
        case (cfg.clock_select)
            CS_DIV1:    tick = 1'b1;
            CS_DIV8:    tick = &prescale_reg[2:0];
            CS_DIV64:   tick = &prescale_reg[5:0];
            CS_DIV256:  tick = &prescale_reg[7:0];
            CS_DIV1024: tick = &prescale_reg[9:0];
            default:    tick = 1'b0;
        endcase
    end

    assign match  = counter_reg == COUNTER_WIDTH'(cfg.compare_value);
    assign at_max = counter_reg == CNT_MAX;
    assign pwm_on = cfg.compare_output_mode == COM_CLEAR || cfg.compare_output_mode == COM_SET;
    assign inv    = cfg.compare_output_mode == COM_SET;

    always_comb begin
        counter_next  = counter_reg;
        down_next     = down_reg;
        pin_next      = pin_reg;
        ovf_next      = ovf_reg & ~item.clear_overflow_flag;
        cmp_next      = cmp_reg & ~item.clear_compare_flag;
        prescale_next = prescale_reg + PRESCALE_WIDTH'(1);
        up            = 1'b1;

        if (item.force_compare && (cfg.wave_mode == WM_NORMAL || cfg.wave_mode == WM_CTC)) begin
            pin_next = tcp_action(pin_reg, cfg.compare_output_mode);
        end

        if (item.load_counter) begin
            counter_next = COUNTER_WIDTH'(item.load_value);
        end else if (tick) begin
            case (cfg.wave_mode)
                WM_NORMAL: begin
                    if (at_max) begin
                        counter_next = '0;
                        ovf_next = 1'b1;
                    end else begin
                        counter_next = counter_reg + CNT_ONE;
                    end
                    if (match) begin
                        cmp_next = 1'b1;
                        pin_next = tcp_action(pin_next, cfg.compare_output_mode);
                    end
                end
                WM_CTC: begin
                    if (at_max) begin
                        counter_next = '0;
                        ovf_next = 1'b1;
                    end else if (match) begin
                        counter_next = '0;
                    end else begin
                        counter_next = counter_reg + CNT_ONE;
                    end
                    if (match) begin
                        cmp_next = 1'b1;
                        pin_next = tcp_action(pin_next, cfg.compare_output_mode);
                    end
                end
                WM_FAST: begin
                    counter_next = at_max ? '0 : counter_reg + CNT_ONE;
                    if (at_max) begin
                        ovf_next = 1'b1;
                    end
                    if (match) begin
                        cmp_next = 1'b1;
                        if (pwm_on) begin
                            pin_next = inv;
                        end
                    end
                    if (at_max && pwm_on) begin
                        pin_next = ~inv;
                    end
                end
                default: begin
                    if (!down_reg) begin
                        if (at_max) begin
                            down_next = 1'b1;
                            counter_next = CNT_MAX - CNT_ONE;
                            up = 1'b0;
                        end else begin
                            counter_next = counter_reg + CNT_ONE;
                        end
                    end else begin
                        if (counter_reg == '0) begin
                            down_next = 1'b0;
                            counter_next = CNT_ONE;
                            ovf_next = 1'b1;
                        end else begin
                            counter_next = counter_reg - CNT_ONE;
                            up = 1'b0;
                        end
                    end
                    if (match) begin
                        cmp_next = 1'b1;
                        if (pwm_on) begin
                            pin_next = up ? inv : ~inv;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prescale_reg <= '0;
            counter_reg  <= '0;
            down_reg     <= 1'b0;
            pin_reg      <= 1'b0;
            ovf_reg      <= 1'b0;
            cmp_reg      <= 1'b0;
        end else if (step) begin
            prescale_reg <= prescale_next;
            counter_reg  <= counter_next;
            down_reg     <= down_next;
            pin_reg      <= pin_next;
            ovf_reg      <= ovf_next;
            cmp_reg      <= cmp_next;
        end
    end

    always_comb begin
        result.count_value   = counter_next[7:0];
        result.wave_out      = pin_next;
        result.overflow_flag = ovf_next;
        result.compare_flag  = cmp_next;
        result.overflow_irq  = ovf_next & cfg.overflow_irq_enable;
        result.compare_irq   = cmp_next & cfg.compare_irq_enable;
    end

endmodule

// File: design/timer_counter_pwm_8bit.sv
// ----------------------------------------------------------------------------
// timer_counter_pwm_8bit: 8-bit timer/counter with compare output and PWM
// Each transfer on the s_ channel is one system clock of the timer. The
// block steps its prescaler, counter, pin level and flags and returns one
// result transfer on the m_ channel with the values after that clock.
// Configuration is written on the cfg_ channel (index 0 wave mode, 1 compare
// output mode, 2 the clock select, 3 compare value, 4 overflow irq enable,
// 5 compare irq enable); the user must write it only while no transfer is
// in flight, the block does not enforce this, and cfg_ready is always high.
// An item waits in the input register, and the step loads the timer state
// and the result register together once the result register is empty or
// being read. Throughput: one transfer per cycle while m_ready does not
// stall the result channel; the timer state is stepped combinationally
// between the two registers.
// When m_ready is low the result holds, the input register fills, and
// s_ready drops only once both registers are full.
// Reset (aresetn low, synchronous) clears the timer state, the configuration
// registers and both valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module timer_counter_pwm_8bit
    import tcp_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  tcp_in_t                    s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output tcp_out_t                   m_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

    tcp_cfg_t cfg;
    tcp_in_t  in_data_reg;
    logic     in_valid_reg;
    tcp_out_t out_data_reg;
    logic     out_valid_reg;
    tcp_out_t result;
    logic     advance;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg & (~out_valid_reg | m_ready);
    assign s_ready   = ~in_valid_reg | advance;

    tcp_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tcp_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .step    (advance),
        .item    (in_data_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// File: design/tcp_checker.sv
// ----------------------------------------------------------------------------
// tcp_checker: port-level checks of the timer/counter
// Result channel hold, interrupt gating and flow control after reset.
// ----------------------------------------------------------------------------
module tcp_checker
    import tcp_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input tcp_out_t m_data
);

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_irq_gated: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_data.overflow_irq || m_data.overflow_flag)
                 && (!m_data.compare_irq || m_data.compare_flag))
        else $error("interrupt without its flag");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid || m_ready |-> s_ready)
        else $error("input stalled with free result slot");

endmodule

bind timer_counter_pwm_8bit tcp_checker u_tcp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// File: tb/sv/timer_pwm_checker.sv
// ----------------------------------------------------------------------------
// timer_pwm_checker: result predictor and scoreboard for the 8-bit timer
// Watches the clock, result and register channels of the timer. Every clock
// transfer steps a private copy of the prescaler, counter, pin and flags and
// queues the outputs that clock must produce; every result transfer is
// compared field by field against the oldest queued outputs.
// ----------------------------------------------------------------------------
module timer_pwm_checker
    import tcp_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  tcp_in_t                    s_data,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  tcp_out_t                   m_data,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    output int                         mismatches,
    output int                         outs_outstanding,
    output int                         outs_checked
);

    localparam logic [7:0] TOP_COUNT = 8'hFF;

    tcp_wave_t  wave;
    tcp_com_t   com;
    logic [2:0] clk_sel;
    logic [7:0] match_val;
    logic       ovf_en;
    logic       cmp_en;

    logic [9:0] presc;
    logic [7:0] count;
    logic       going_down;
    logic       pin;
    logic       ovf_f;
    logic       cmp_f;

    tcp_out_t   clock_outs[$];

    initial begin
        mismatches = 0;
        outs_outstanding = 0;
        outs_checked = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    function automatic logic prescaler_fires();
        case (clk_sel)
            CS_DIV1:    return 1'b1;
            CS_DIV8:    return &presc[2:0];
            CS_DIV64:   return &presc[5:0];
            CS_DIV256:  return &presc[7:0];
            CS_DIV1024: return &presc[9:0];
            default:    return 1'b0;
        endcase
    endfunction

    function automatic logic apply_com(input logic lvl);
        case (com)
            COM_TOGGLE: return ~lvl;
            COM_CLEAR:  return 1'b0;
            COM_SET:    return 1'b1;
            default:    return lvl;
        endcase
    endfunction

    function automatic void count_tick();
        logic [7:0] old;
        logic       hit;
        logic       pwm_on;
        logic       inv;
        logic       up;
        old = count;
        hit = (old == match_val);
        pwm_on = (com == COM_CLEAR) || (com == COM_SET);
        inv = (com == COM_SET);
        up = 1'b1;
        case (wave)
            WM_NORMAL: begin
                if (old == TOP_COUNT) begin
                    count = 8'd0;
                    ovf_f = 1'b1;
                end else begin
                    count = old + 8'd1;
                end
                if (hit) begin
                    cmp_f = 1'b1;
                    pin = apply_com(pin);
                end
            end
            WM_CTC: begin
                if (old == TOP_COUNT) begin
                    count = 8'd0;
                    ovf_f = 1'b1;
                end else if (hit) begin
                    count = 8'd0;
                end else begin
                    count = old + 8'd1;
                end
                if (hit) begin
                    cmp_f = 1'b1;
                    pin = apply_com(pin);
                end
            end
            WM_FAST: begin
                count = (old == TOP_COUNT) ? 8'd0 : old + 8'd1;
                if (old == TOP_COUNT)
                    ovf_f = 1'b1;
                if (hit) begin
                    cmp_f = 1'b1;
                    if (pwm_on)
                        pin = inv;
                end
                // bottom action overrides a match on the same tick
                if (old == TOP_COUNT && pwm_on)
                    pin = ~inv;
            end
            default: begin
                if (!going_down) begin
                    if (old == TOP_COUNT) begin
                        going_down = 1'b1;
                        count = TOP_COUNT - 8'd1;
                        up = 1'b0;
                    end else begin
                        count = old + 8'd1;
                    end
                end else begin
                    if (old == 8'd0) begin
                        going_down = 1'b0;
                        count = 8'd1;
                        ovf_f = 1'b1;
                    end else begin
                        count = old - 8'd1;
                        up = 1'b0;
                    end
                end
                if (hit) begin
                    cmp_f = 1'b1;
                    if (pwm_on)
                        pin = up ? inv : ~inv;
                end
            end
        endcase
    endfunction

    function automatic tcp_out_t step_clock(input tcp_in_t d);
        logic     fire;
        tcp_out_t r;
        fire = prescaler_fires();
        if (d.clear_overflow_flag)
            ovf_f = 1'b0;
        if (d.clear_compare_flag)
            cmp_f = 1'b0;
        if (d.force_compare && (wave == WM_NORMAL || wave == WM_CTC))
            pin = apply_com(pin);
        if (d.load_counter)
            count = d.load_value;
        else if (fire)
            count_tick();
        presc = presc + 10'd1;
        r.count_value = count;
        r.wave_out = pin;
        r.overflow_flag = ovf_f;
        r.compare_flag = cmp_f;
        r.overflow_irq = ovf_f & ovf_en;
        r.compare_irq = cmp_f & cmp_en;
        return r;
    endfunction

    task automatic write_setting(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                 input logic [CFG_DATA_WIDTH-1:0] val);
        case (idx)
            REG_WAVE_MODE:    wave = tcp_wave_t'(val[1:0]);
            REG_COM_MODE:     com = tcp_com_t'(val[1:0]);
            REG_CLOCK_SELECT: clk_sel = val[2:0];
            REG_COMPARE:      match_val = val;
            REG_OVF_IRQ_EN:   ovf_en = val[0];
            REG_CMP_IRQ_EN:   cmp_en = val[0];
            default: ;
        endcase
    endtask

    task automatic check_result(input tcp_out_t got);
        tcp_out_t want;
        if (clock_outs.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected, count_value %0d",
                                      got.count_value));
        end else begin
            want = clock_outs.pop_front();
            outs_checked++;
            if (got.count_value !== want.count_value)
                report_mismatch($sformatf("count_value got %0d want %0d",
                                          got.count_value, want.count_value));
            if (got.wave_out !== want.wave_out)
                report_mismatch($sformatf("wave_out got %b want %b",
                                          got.wave_out, want.wave_out));
            if (got.overflow_flag !== want.overflow_flag)
                report_mismatch($sformatf("overflow_flag got %b want %b",
                                          got.overflow_flag, want.overflow_flag));
            if (got.compare_flag !== want.compare_flag)
                report_mismatch($sformatf("compare_flag got %b want %b",
                                          got.compare_flag, want.compare_flag));
            if (got.overflow_irq !== want.overflow_irq)
                report_mismatch($sformatf("overflow_irq got %b want %b",
                                          got.overflow_irq, want.overflow_irq));
            if (got.compare_irq !== want.compare_irq)
                report_mismatch($sformatf("compare_irq got %b want %b",
                                          got.compare_irq, want.compare_irq));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            wave = WM_NORMAL;
            com = COM_OFF;
            clk_sel = CS_STOP;
            match_val = 8'd0;
            ovf_en = 1'b0;
            cmp_en = 1'b0;
            presc = 10'd0;
            count = 8'd0;
            going_down = 1'b0;
            pin = 1'b0;
            ovf_f = 1'b0;
            cmp_f = 1'b0;
            clock_outs.delete();
        end else begin
            if (m_valid && m_ready)
                check_result(m_data);
            if (cfg_valid && cfg_ready)
                write_setting(cfg_index, cfg_data);
            if (s_valid && s_ready)
                clock_outs.push_back(step_clock(s_data));
        end
        outs_outstanding = clock_outs.size();
    end

endmodule

// File: tb/sv/tb_timer_counter_pwm_8bit.sv
// ----------------------------------------------------------------------------
// tb_timer_counter_pwm_8bit: testbench top of the 8-bit timer/counter
// Drives timer clocks with random gaps, register writes and result
// back-pressure, including one long receiver stall. A directed opening hits
// wrap, bottom, turnaround, force and flag corner cases; random setups with
// mostly fast prescaling follow. Results are checked by timer_pwm_checker.
// ----------------------------------------------------------------------------
module tb_timer_counter_pwm_8bit;
    import tcp_pkg::*;

    localparam logic [2:0] CS_SPARE_LO = 3'd6;
    localparam logic [2:0] CS_SPARE_HI = 3'd7;
    localparam int         RANDOM_CLOCKS = 950;

    logic                       aclk;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    tcp_in_t                    s_data = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    tcp_out_t                   m_data;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;

    int mismatches;
    int outs_outstanding;
    int outs_checked;

    int tx_max = 0;
    int rx_max = 0;
    bit hold_req = 1'b0;
    int clocks_sent = 0;
    int setups_run = 0;

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    timer_counter_pwm_8bit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    timer_pwm_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data           (s_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_data           (m_data),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mismatches       (mismatches),
        .outs_outstanding (outs_outstanding),
        .outs_checked     (outs_checked)
    );

    function automatic logic [7:0] pad(input logic [7:0] v, input logic [7:0] keep);
        return (v & keep) | (8'($urandom) & ~keep);
    endfunction

    function automatic tcp_in_t clk_item(input logic ld, input logic [7:0] val,
                                         input logic c_ovf, input logic c_cmp,
                                         input logic frc);
        tcp_in_t d;
        d.load_counter = ld;
        d.load_value = val;
        d.clear_overflow_flag = c_ovf;
        d.clear_compare_flag = c_cmp;
        d.force_compare = frc;
        return d;
    endfunction

    function automatic tcp_in_t random_clock(input logic [7:0] cmpv);
        tcp_in_t d;
        d.load_counter = ($urandom_range(0, 11) == 0);
        case ($urandom_range(0, 6))
            0: d.load_value = 8'd0;
            1: d.load_value = 8'hFF;
            2: d.load_value = 8'hFE;
            3: d.load_value = cmpv;
            4: d.load_value = cmpv - 8'd1;
            5: d.load_value = cmpv - 8'd2;
            default: d.load_value = 8'($urandom);
        endcase
        d.clear_overflow_flag = ($urandom_range(0, 9) == 0);
        d.clear_compare_flag = ($urandom_range(0, 9) == 0);
        d.force_compare = ($urandom_range(0, 9) == 0);
        return d;
    endfunction

    task automatic send_clock(input tcp_in_t d);
        int gap;
        gap = $urandom_range(0, tx_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_data <= d;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        clocks_sent++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic set_timer(input tcp_wave_t wm, input tcp_com_t cm,
                             input logic [2:0] cs, input logic [7:0] cmpv,
                             input logic oen, input logic cen);
        write_reg(REG_WAVE_MODE, pad(8'(wm), 8'h03));
        write_reg(REG_COM_MODE, pad(8'(cm), 8'h03));
        write_reg(REG_CLOCK_SELECT, pad(8'(cs), 8'h07));
        write_reg(REG_COMPARE, cmpv);
        write_reg(REG_OVF_IRQ_EN, pad(8'(oen), 8'h01));
        write_reg(REG_CMP_IRQ_EN, pad(8'(cen), 8'h01));
        cfg_valid <= 1'b0;
        setups_run++;
    endtask

    // drain all results, then give the pipeline time to go quiet
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outs_outstanding != 0);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        int n;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                n = 80;
                hold_req = 1'b0;
            end else begin
                n = $urandom_range(0, rx_max);
            end
            if (n > 0) begin
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    initial begin
        #400000;
        $display("[timer_counter_pwm_8bit] ERROR");
        $finish;
    end

    initial begin
        int         random_sent;
        int         setup_idx;
        int         len;
        tcp_wave_t  wm;
        tcp_com_t   cm;
        logic [2:0] cs;
        logic [7:0] cmpv;
        random_sent = 0;
        setup_idx = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_max = 3;
        rx_max = 3;

        // stopped timer after reset: loads at both extremes, force with pin off
        send_clock(clk_item(1'b1, 8'hFF, 1'b0, 1'b0, 1'b0));
        send_clock(clk_item(1'b1, 8'h00, 1'b0, 1'b0, 1'b0));
        send_clock(clk_item(1'b0, 8'hFF, 1'b0, 1'b0, 1'b1));
        send_clock(clk_item(1'b0, 8'h00, 1'b1, 1'b1, 1'b0));
        settle();

        // normal wrap with match at top, clear requests losing to hw set
        set_timer(WM_NORMAL, COM_TOGGLE, CS_DIV1, 8'hFF, 1'b1, 1'b1);
        send_clock(clk_item(1'b1, 8'hFE, 1'b0, 1'b0, 1'b0));
        send_clock(clk_item(1'b0, 8'h00, 1'b0, 1'b0, 1'b0));
        send_clock(clk_item(1'b0, 8'h00, 1'b1, 1'b1, 1'b0));
        send_clock(clk_item(1'b0, 8'h00, 1'b0, 1'b0, 1'b1));
        send_clock(clk_item(1'b0, 8'h00, 1'b1, 1'b1, 1'b0));
        settle();

        // unused clock select: stopped, force still sets the pin
        set_timer(WM_CTC, COM_SET, CS_SPARE_LO, 8'h00, 1'b0, 1'b1);
        send_clock(clk_item(1'b0, 8'h00, 1'b0, 1'b0, 1'b1));
        send_clock(clk_item(1'b0, 8'h00, 1'b0, 1'b0, 1'b0));
        settle();

        // fast pwm: bottom and match on one tick, force ignored
        set_timer(WM_FAST, COM_CLEAR, CS_DIV1, 8'hFF, 1'b1, 1'b0);
        send_clock(clk_item(1'b1, 8'hFE, 1'b0, 1'b0, 1'b0));
        send_clock(clk_item(1'b0, 8'h00, 1'b0, 1'b0, 1'b0));
        send_clock(clk_item(1'b0, 8'h00, 1'b0, 1'b0, 1'b0));
        send_clock(clk_item(1'b0, 8'h00, 1'b0, 1'b0, 1'b1));
        settle();

        // phase correct: turn at top, load while down, turn at bottom
        set_timer(WM_PHASE, COM_SET, CS_DIV1, 8'h00, 1'b1, 1'b1);
        send_clock(clk_item(1'b1, 8'hFE, 1'b0, 1'b0, 1'b0));
        send_clock(clk_item(1'b0, 8'h00, 1'b0, 1'b0, 1'b0));
        send_clock(clk_item(1'b0, 8'h00, 1'b0, 1'b0, 1'b0));
        send_clock(clk_item(1'b1, 8'h01, 1'b0, 1'b0, 1'b0));
        send_clock(clk_item(1'b0, 8'h00, 1'b0, 1'b0, 1'b0));
        send_clock(clk_item(1'b0, 8'h00, 1'b0, 1'b0, 1'b0));
        settle();

        while (random_sent < RANDOM_CLOCKS) begin
            wm = tcp_wave_t'($urandom_range(0, 3));
            cm = tcp_com_t'($urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: cs = CS_DIV1;
                5, 6:          cs = CS_DIV8;
                7:             cs = CS_DIV64;
                8: begin
                    case ($urandom_range(0, 2))
                        0:       cs = CS_STOP;
                        1:       cs = CS_SPARE_LO;
                        default: cs = CS_SPARE_HI;
                    endcase
                end
                default: cs = $urandom_range(0, 1) ? CS_DIV256 : CS_DIV1024;
            endcase
            case ($urandom_range(0, 3))
                0:       cmpv = 8'h00;
                1:       cmpv = 8'hFF;
                default: cmpv = 8'($urandom);
            endcase
            tx_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
            rx_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
            if (setup_idx == 2) begin
                tx_max = 0;
                hold_req = 1'b1;
            end
            set_timer(wm, cm, cs, cmpv, 1'($urandom), 1'($urandom));
            len = $urandom_range(40, 120);
            repeat (len) begin
                send_clock(random_clock(cmpv));
                random_sent++;
            end
            settle();
            setup_idx++;
        end

        repeat (6) @(posedge aclk);
        $display("Covered %0d timer clocks over %0d register setups", clocks_sent, setups_run);
        $display("Compared %0d results, %0d field mismatches", outs_checked, mismatches);
        if (mismatches == 0) begin
            $display("[timer_counter_pwm_8bit] OK");
        end else begin
            $display("[timer_counter_pwm_8bit] ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
design/tcp_pkg.sv
design/tcp_cfg_regs.sv
design/tcp_core.sv
design/timer_counter_pwm_8bit.sv
design/tcp_checker.sv
tb/sv/timer_pwm_checker.sv
tb/sv/tb_timer_counter_pwm_8bit.sv
